### rtl/buck_boost_bang_bang_gate_control_macros.svh
// Assertion macros used by the gate control checker.
`ifndef BUCK_BOOST_BANG_BANG_GATE_CONTROL_MACROS_SVH
`define BUCK_BOOST_BANG_BANG_GATE_CONTROL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BBGC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BBGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bbgc_pkg.sv
// Package with widths, register indexes, mode codes and gate bits of the gate control.
`timescale 1ns / 1ps

package bbgc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 12;
    localparam int CFG_WIDTH        = 12;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int GATE_WIDTH       = 4;
    localparam int MODE_WIDTH       = 3;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [CFG_WIDTH-1:0]       cfg_word_t;
    typedef logic [GATE_WIDTH-1:0]      gate_t;
    typedef logic [MODE_WIDTH-1:0]      mode_t;

    localparam cfg_index_t REG_TARGET     = 2'd0;
    localparam cfg_index_t REG_OV_LIMIT   = 2'd1;
    localparam cfg_index_t REG_CUR_LIMIT  = 2'd2;
    localparam cfg_index_t REG_ENABLE     = 2'd3;

    localparam cfg_word_t  TARGET_RST     = 12'h000;
    localparam cfg_word_t  OV_LIMIT_RST   = 12'hFFF;
    localparam cfg_word_t  CUR_LIMIT_RST  = 12'hFFF;

    localparam mode_t MODE_ALLOFF    = 3'd0;
    localparam mode_t MODE_BUCKOFF   = 3'd1;
    localparam mode_t MODE_BUCKSOFT  = 3'd2;
    localparam mode_t MODE_BUCKON    = 3'd3;
    localparam mode_t MODE_BOOSTOFF  = 3'd4;
    localparam mode_t MODE_BOOSTSOFT = 3'd5;
    localparam mode_t MODE_BOOSTON   = 3'd6;
    localparam mode_t MODE_DISCHARGE = 3'd7;

    localparam gate_t GATE_NONE = 4'h0;
    localparam gate_t GATE_N1   = 4'h1;
    localparam gate_t GATE_P1   = 4'h2;
    localparam gate_t GATE_N2   = 4'h4;
    localparam gate_t GATE_P2   = 4'h8;
    localparam gate_t GATE_ALL  = 4'hF;

endpackage

### rtl/buck_boost_bang_bang_gate_control.sv
// Top level of the bang-bang buck-boost gate control: mode pick and gate update.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  input     | in_valid / in_stall    | out_voltage, in_voltage, coil_current
//  output    | out_valid / out_stall  | gate_drive, conv_mode
//  config    | cfg_we                 | cfg_index, cfg_data
//
//  One transaction per cycle sustained while out_stall is low; from input
//  to result a sample passes the sample register, then the mode and gate
//  logic into the result register, which also holds the gate state.
//  Reset sets gates and mode to all off and config registers to defaults.
//  A stalled output holds the result; the sample register keeps taking
//  input while it is empty or the result register can advance.
`timescale 1ns / 1ps

module buck_boost_bang_bang_gate_control #(
    parameter int SAMPLE_WIDTH = bbgc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_WIDTH-1:0]       out_voltage,
    input  logic [SAMPLE_WIDTH-1:0]       in_voltage,
    input  logic signed [SAMPLE_WIDTH:0]  coil_current,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bbgc_pkg::gate_t               gate_drive,
    output bbgc_pkg::mode_t               conv_mode,
    input  logic                          cfg_we,
    input  bbgc_pkg::cfg_index_t          cfg_index,
    input  bbgc_pkg::cfg_word_t           cfg_data
);

    import bbgc_pkg::*;

    localparam int CMP_W = ((SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH) + 2;

    cfg_word_t                   target_reg;
    cfg_word_t                   ov_limit_reg;
    cfg_word_t                   cur_limit_reg;
    logic                        enable_reg;

    logic                        s1_valid_reg;
    logic [SAMPLE_WIDTH-1:0]     s1_vo_reg;
    logic [SAMPLE_WIDTH-1:0]     s1_vi_reg;
    logic signed [SAMPLE_WIDTH:0] s1_il_reg;

    logic                        out_valid_reg;
    gate_t                       gate_reg;
    mode_t                       mode_reg;
    gate_t                       gate_next;
    mode_t                       mode_next;

    logic                        adv_out;
    logic                        load_s1;
    logic                        load_out;

    logic signed [CMP_W-1:0]     vo_x;
    logic signed [CMP_W-1:0]     vi_x;
    logic signed [CMP_W-1:0]     il_x;
    logic signed [CMP_W-1:0]     tgt_x;
    logic signed [CMP_W-1:0]     ovl_x;
    logic signed [CMP_W-1:0]     curl_x;

    // One half-bridge leg: clear a conflicting gate first, else turn on the wanted one.
    function automatic gate_t leg(input gate_t g, input gate_t want, input gate_t other);
        gate_t r;
        if (want == GATE_NONE)
            r = g & ~other;
        else if ((g & other) != GATE_NONE)
            r = g & ~other;
        else
            r = g | want;
        return r;
    endfunction

    function automatic gate_t gate_update(input gate_t g, input mode_t m);
        gate_t r;
        case (m)
            MODE_BUCKOFF:   r = leg(leg(g, GATE_N1, GATE_P1), GATE_P2, GATE_N2);
            MODE_BUCKSOFT:  r = leg(leg(g, GATE_NONE, GATE_N1 | GATE_P1), GATE_P2, GATE_N2);
            MODE_BUCKON,
            MODE_BOOSTOFF:  r = leg(leg(g, GATE_P1, GATE_N1), GATE_P2, GATE_N2);
            MODE_BOOSTSOFT: r = leg(leg(g, GATE_P1, GATE_N1), GATE_NONE, GATE_N2 | GATE_P2);
            MODE_BOOSTON:   r = leg(leg(g, GATE_P1, GATE_N1), GATE_N2, GATE_P2);
            MODE_DISCHARGE: r = leg(leg(g, GATE_N1, GATE_P1), GATE_N2, GATE_P2);
            default:        r = GATE_NONE;
        endcase
        return r & GATE_ALL;
    endfunction

    // Handshake: the sample register moves on whenever the result register can take it.
    assign adv_out  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !adv_out;
    assign load_s1  = in_valid && !in_stall;
    assign load_out = s1_valid_reg && adv_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RST;
            ov_limit_reg  <= OV_LIMIT_RST;
            cur_limit_reg <= CUR_LIMIT_RST;
            enable_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET:    target_reg    <= cfg_data;
                REG_OV_LIMIT:  ov_limit_reg  <= cfg_data;
                REG_CUR_LIMIT: cur_limit_reg <= cfg_data;
                REG_ENABLE:    enable_reg    <= cfg_data[0];
                default:       enable_reg    <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv_out || !s1_valid_reg)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_vo_reg <= out_voltage;
            s1_vi_reg <= in_voltage;
            s1_il_reg <= coil_current;
        end
    end

    // Widen everything to one signed width so mixed comparisons stay exact.
    assign vo_x   = signed'(CMP_W'(s1_vo_reg));
    assign vi_x   = signed'(CMP_W'(s1_vi_reg));
    assign il_x   = CMP_W'(s1_il_reg);
    assign tgt_x  = signed'(CMP_W'(target_reg));
    assign ovl_x  = signed'(CMP_W'(ov_limit_reg));
    assign curl_x = signed'(CMP_W'(cur_limit_reg));

    always_comb
    begin
        if (!enable_reg || target_reg == TARGET_RST)
            mode_next = MODE_ALLOFF;
        else if (vo_x > ovl_x)
            mode_next = MODE_DISCHARGE;
        else if (il_x > curl_x)
            mode_next = (vo_x > vi_x) ? MODE_BOOSTOFF : MODE_BUCKOFF;
        else if (tgt_x > vi_x)
        begin
            if (vo_x <= tgt_x)
                mode_next = MODE_BOOSTON;
            else
                mode_next = (il_x <= 0) ? MODE_BOOSTSOFT : MODE_BOOSTOFF;
        end
        else if (vo_x <= tgt_x)
            mode_next = MODE_BUCKON;
        else
            mode_next = (il_x <= 0) ? MODE_BUCKSOFT : MODE_BUCKOFF;
    end

    assign gate_next = gate_update(gate_reg, mode_next);

    // The result register doubles as the gate and mode state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            gate_reg      <= GATE_NONE;
            mode_reg      <= MODE_ALLOFF;
        end
        else
        begin
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
            if (load_out)
            begin
                gate_reg <= gate_next;
                mode_reg <= mode_next;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign gate_drive = gate_reg;
    assign conv_mode  = mode_reg;

endmodule

### rtl/bbgc_checker.sv
// Port checker for the gate control, bound to the top level.
`timescale 1ns / 1ps
`include "buck_boost_bang_bang_gate_control_macros.svh"

module bbgc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_stall,
    input bbgc_pkg::gate_t gate_drive,
    input bbgc_pkg::mode_t conv_mode
);

    import bbgc_pkg::*;

    // Never both gates of one leg at once while out_valid is high.
    `BBGC_ASSERT_NOW(a_no_shoot_through, clk, rst_n, out_valid, !(gate_drive[0] && gate_drive[1]) && !(gate_drive[2] && gate_drive[3]), "both gates of a leg on")

    `BBGC_ASSERT_NOW(a_alloff_gates, clk, rst_n, out_valid && conv_mode == MODE_ALLOFF, gate_drive == GATE_NONE, "gates on in all off mode")

    `BBGC_ASSERT_NOW(a_discharge_no_p, clk, rst_n, out_valid && conv_mode == MODE_DISCHARGE, !gate_drive[1] && !gate_drive[3], "high side gate on in discharge")

    // Hold a stalled transaction.
    `BBGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(gate_drive) && $stable(conv_mode), "stalled result changed")

endmodule

bind buck_boost_bang_bang_gate_control bbgc_checker u_bbgc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .gate_drive (gate_drive),
    .conv_mode  (conv_mode)
);
